@@ rtl/core/acpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acpc_pkg;

	// Field widths
	localparam int SLOT_W     = 8;
	localparam int VALUE_W    = 16;
	localparam int TICKS_W    = 16;
	localparam int PULSE_W    = 11;
	localparam int CMP_W      = 19;
	localparam int CH_W       = 3;
	localparam int CHAN_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Slot mapping
	localparam int SLOT_COUNT = 4;
	localparam int MAP_REGS   = 4;
	localparam int MAP_IDX_W  = $clog2(MAP_REGS);

	// Pulse arithmetic
	localparam int PULSE_MID   = 1500;
	localparam int PULSE_MIN   = 1000;
	localparam int PULSE_MAX   = 2000;
	localparam int PULSE_SPAN  = 500;
	localparam int RAW_FULL    = 8192;
	localparam int Q_FRAC      = 14;
	localparam int PROD_W      = 25;
	localparam int QUOT_W      = PROD_W - Q_FRAC;
	localparam int SUM_W       = 13;
	localparam int TICKS_RESET = 256;
	localparam int TICKS_FRAC  = 8;
	localparam int TPROD_W     = PULSE_W + TICKS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_SLOT0 = 3'd0,
		REG_MAP_SLOT1 = 3'd1,
		REG_MAP_SLOT2 = 3'd2,
		REG_MAP_SLOT3 = 3'd3,
		REG_TICKS     = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		CMD_NORM = 1'b0,
		CMD_RAW  = 1'b1
	} cmd_t;

	typedef logic [MAP_REGS-1:0][CH_W-1:0] map_arr_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

`default_nettype wire

@@ rtl/core/acpc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpc_cfg (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [acpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [acpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output acpc_pkg::map_arr_t                   map_slot,
	output logic [acpc_pkg::TICKS_W-1:0]         ticks_per_us
);

	acpc_pkg::map_arr_t                  map_q;
	logic [acpc_pkg::TICKS_W-1:0]        ticks_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acpc_pkg::MAP_REGS; i++) begin
				map_q[i] <= acpc_pkg::CH_W'(i);
			end
			ticks_q <= acpc_pkg::TICKS_W'(acpc_pkg::TICKS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				acpc_pkg::REG_MAP_SLOT0: map_q[0] <= cfg_data[acpc_pkg::CH_W-1:0];
				acpc_pkg::REG_MAP_SLOT1: map_q[1] <= cfg_data[acpc_pkg::CH_W-1:0];
				acpc_pkg::REG_MAP_SLOT2: map_q[2] <= cfg_data[acpc_pkg::CH_W-1:0];
				acpc_pkg::REG_MAP_SLOT3: map_q[3] <= cfg_data[acpc_pkg::CH_W-1:0];
				acpc_pkg::REG_TICKS:     ticks_q  <= cfg_data[acpc_pkg::TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign map_slot     = map_q;
	assign ticks_per_us = ticks_q;

endmodule

`default_nettype wire

@@ rtl/core/acpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire                 out_stall,
	output acpc_pkg::stage_en_t en
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// A stage loads when it is empty or its contents move on
	always_comb begin
		en.s5 = !valid_s5 || !out_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s5;

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	// Input stalls only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled with a free stage");

	// A free receiver never holds back the sender
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// An accepted beat occupies the first stage
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat lost at first stage");

	// A held last stage implies a stalled receiver
	a_hold_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!en.s5 |-> (valid_s5 && out_stall))
		else $error("last stage held without stall");

endmodule

`default_nettype wire

@@ rtl/core/acpc_pulse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpc_pulse (
	input  wire                                  clk,
	input  acpc_pkg::stage_en_t                  en,
	input  acpc_pkg::map_arr_t                   map_slot,
	input  wire                                  cmd,
	input  wire  [acpc_pkg::SLOT_W-1:0]          slot,
	input  wire  signed [acpc_pkg::VALUE_W-1:0]  value,
	output logic                                 hit_s3,
	output logic [acpc_pkg::CHAN_W-1:0]          chan_s3,
	output logic [acpc_pkg::PULSE_W-1:0]         pulse_s3
);

	localparam logic signed [acpc_pkg::VALUE_W-1:0] RAW_HI =
		acpc_pkg::VALUE_W'(acpc_pkg::RAW_FULL);
	localparam logic signed [acpc_pkg::VALUE_W-1:0] RAW_LO =
		acpc_pkg::VALUE_W'(-acpc_pkg::RAW_FULL);
	localparam logic signed [acpc_pkg::PROD_W-1:0] SPAN_S =
		acpc_pkg::PROD_W'(acpc_pkg::PULSE_SPAN);
	localparam logic signed [acpc_pkg::PROD_W-1:0] TRUNC_BIAS =
		acpc_pkg::PROD_W'((1 << acpc_pkg::Q_FRAC) - 1);
	localparam logic signed [acpc_pkg::SUM_W-1:0] MID_S =
		acpc_pkg::SUM_W'(acpc_pkg::PULSE_MID);
	localparam logic signed [acpc_pkg::SUM_W-1:0] MIN_S =
		acpc_pkg::SUM_W'(acpc_pkg::PULSE_MIN);
	localparam logic signed [acpc_pkg::SUM_W-1:0] MAX_S =
		acpc_pkg::SUM_W'(acpc_pkg::PULSE_MAX);

	logic signed [acpc_pkg::VALUE_W-1:0] raw_clamped;
	logic signed [acpc_pkg::VALUE_W-1:0] op;
	logic                                slot_ok;
	logic [acpc_pkg::CH_W-1:0]           map_sel;
	logic                                hit;
	logic [acpc_pkg::CHAN_W-1:0]         chan;

	logic signed [acpc_pkg::VALUE_W-1:0] op_s1;
	logic                                hit_s1;
	logic [acpc_pkg::CHAN_W-1:0]         chan_s1;

	logic signed [acpc_pkg::PROD_W-1:0]  prod_s2;
	logic                                hit_s2;
	logic [acpc_pkg::CHAN_W-1:0]         chan_s2;

	logic signed [acpc_pkg::PROD_W-1:0]  prod_adj;
	logic signed [acpc_pkg::QUOT_W-1:0]  quot;
	logic signed [acpc_pkg::SUM_W-1:0]   pulse_sum;
	logic [acpc_pkg::PULSE_W-1:0]        pulse_clamped;

	// Raw values saturate at full scale and double onto the Q2.14 grid
	always_comb begin
		if (value > RAW_HI) begin
			raw_clamped = RAW_HI;
		end else if (value < RAW_LO) begin
			raw_clamped = RAW_LO;
		end else begin
			raw_clamped = value;
		end
		op = (cmd == acpc_pkg::CMD_RAW) ? (raw_clamped <<< 1) : value;
	end

	// Look up the physical channel; a negative map entry disables the slot
	always_comb begin
		slot_ok = (slot < acpc_pkg::SLOT_W'(acpc_pkg::SLOT_COUNT)) &&
			(slot < acpc_pkg::SLOT_W'(acpc_pkg::MAP_REGS));
		map_sel = map_slot[slot[acpc_pkg::MAP_IDX_W-1:0]];
		hit     = slot_ok && !map_sel[acpc_pkg::CH_W-1];
		chan    = hit ? map_sel[acpc_pkg::CHAN_W-1:0] : '0;
	end

	// Stage 1: operand and channel
	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1   <= op;
			hit_s1  <= hit;
			chan_s1 <= chan;
		end
	end

	// Stage 2: scale by the pulse span
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= acpc_pkg::PROD_W'(op_s1) * SPAN_S;
			hit_s2  <= hit_s1;
			chan_s2 <= chan_s1;
		end
	end

	// Truncate toward zero, centre on mid pulse, clamp to the servo range
	always_comb begin
		prod_adj  = prod_s2 + (prod_s2[acpc_pkg::PROD_W-1] ? TRUNC_BIAS : '0);
		quot      = acpc_pkg::QUOT_W'(prod_adj >>> acpc_pkg::Q_FRAC);
		pulse_sum = acpc_pkg::SUM_W'(quot) + MID_S;
		if (pulse_sum < MIN_S) begin
			pulse_clamped = acpc_pkg::PULSE_W'(acpc_pkg::PULSE_MIN);
		end else if (pulse_sum > MAX_S) begin
			pulse_clamped = acpc_pkg::PULSE_W'(acpc_pkg::PULSE_MAX);
		end else begin
			pulse_clamped = pulse_sum[acpc_pkg::PULSE_W-1:0];
		end
	end

	// Stage 3: pulse width
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pulse_s3 <= pulse_clamped;
			hit_s3   <= hit_s2;
			chan_s3  <= chan_s2;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/acpc_ccr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpc_ccr (
	input  wire                                  clk,
	input  acpc_pkg::stage_en_t                  en,
	input  wire  [acpc_pkg::TICKS_W-1:0]         ticks_per_us,
	input  wire                                  hit_s3,
	input  wire  [acpc_pkg::CHAN_W-1:0]          chan_s3,
	input  wire  [acpc_pkg::PULSE_W-1:0]         pulse_s3,
	output logic                                 hit_s5,
	output logic [acpc_pkg::CHAN_W-1:0]          chan_s5,
	output logic [acpc_pkg::PULSE_W-1:0]         pulse_s5,
	output logic [acpc_pkg::CMP_W-1:0]           cmp_s5
);

	logic [acpc_pkg::TPROD_W-1:0]  tprod_s4;
	logic                          hit_s4;
	logic [acpc_pkg::CHAN_W-1:0]   chan_s4;
	logic [acpc_pkg::PULSE_W-1:0]  pulse_s4;

	// Stage 4: pulse times Q8.8 tick rate
	always_ff @(posedge clk) begin
		if (en.s4) begin
			tprod_s4 <= acpc_pkg::TPROD_W'(pulse_s3) * acpc_pkg::TPROD_W'(ticks_per_us);
			hit_s4   <= hit_s3;
			chan_s4  <= chan_s3;
			pulse_s4 <= pulse_s3;
		end
	end

	// Stage 5: drop the fraction and hold the result beat
	always_ff @(posedge clk) begin
		if (en.s5) begin
			cmp_s5   <= tprod_s4[acpc_pkg::TICKS_FRAC +: acpc_pkg::CMP_W];
			hit_s5   <= hit_s4;
			chan_s5  <= chan_s4;
			pulse_s5 <= pulse_s4;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/actuator_command_to_pwm_compare.sv @@
// Actuator command to PWM compare mapping.
// Input channel (in_valid/in_stall): one command beat of cmd, slot and
// value. cmd low takes value as Q2.14, cmd high as a raw ESC value with 8192
// as full scale. The pulse width is clamped to 1000..2000 us.
// Output channel (out_valid/out_stall): one result beat per command with
// write_valid, channel, pulse_width and compare_value (pulse times the Q8.8
// tick rate, fraction dropped). write_valid is low for a slot of 4 or more
// or a negative map entry, and channel then reads 0.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..3 slot
// map, 4 tick rate); write only while no beat is in flight.
// A beat moves through stages s1 to s5 in order and out_valid is the valid bit
// of s5; throughput is one beat per cycle while out_stall is low, with the
// five register stages and the two multipliers each owning one stage.
// Reset clears all stage valid bits and loads the default map and a tick rate
// of 1.0. When the receiver stalls, the last stage holds its beat and bubbles
// upstream fill; in_stall rises only once all five stages are full.
`timescale 1ns / 1ps
`default_nettype none

module actuator_command_to_pwm_compare (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [acpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [acpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  cmd,
	input  wire  [acpc_pkg::SLOT_W-1:0]          slot,
	input  wire  signed [acpc_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 write_valid,
	output logic [acpc_pkg::CHAN_W-1:0]          channel,
	output logic [acpc_pkg::PULSE_W-1:0]         pulse_width,
	output logic [acpc_pkg::CMP_W-1:0]           compare_value
);

	acpc_pkg::stage_en_t             en;
	acpc_pkg::map_arr_t              map_slot;
	logic [acpc_pkg::TICKS_W-1:0]    ticks_per_us;
	logic                            hit_s3;
	logic [acpc_pkg::CHAN_W-1:0]     chan_s3;
	logic [acpc_pkg::PULSE_W-1:0]    pulse_s3;

	acpc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.map_slot     (map_slot),
		.ticks_per_us (ticks_per_us)
	);

	acpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	acpc_pulse u_pulse (
		.clk      (clk),
		.en       (en),
		.map_slot (map_slot),
		.cmd      (cmd),
		.slot     (slot),
		.value    (value),
		.hit_s3   (hit_s3),
		.chan_s3  (chan_s3),
		.pulse_s3 (pulse_s3)
	);

	acpc_ccr u_ccr (
		.clk          (clk),
		.en           (en),
		.ticks_per_us (ticks_per_us),
		.hit_s3       (hit_s3),
		.chan_s3      (chan_s3),
		.pulse_s3     (pulse_s3),
		.hit_s5       (write_valid),
		.chan_s5      (channel),
		.pulse_s5     (pulse_width),
		.cmp_s5       (compare_value)
	);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		acpc_pkg::cmd_t                       mode;
		logic [acpc_pkg::SLOT_W-1:0]          slot_id;
		logic signed [acpc_pkg::VALUE_W-1:0]  level;
	} command_t;

	typedef struct {
		logic                          write_valid;
		logic [acpc_pkg::CHAN_W-1:0]   channel;
		logic [acpc_pkg::PULSE_W-1:0]  pulse_width;
		logic [acpc_pkg::CMP_W-1:0]    compare_value;
	} compare_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [acpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [acpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	acpc_pkg::cmd_t cmd = acpc_pkg::CMD_NORM;
	logic [acpc_pkg::SLOT_W-1:0] slot = '0;
	logic signed [acpc_pkg::VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic write_valid;
	logic [acpc_pkg::CHAN_W-1:0] channel;
	logic [acpc_pkg::PULSE_W-1:0] pulse_width;
	logic [acpc_pkg::CMP_W-1:0] compare_value;

	// shadow of the block's registers, changed only while idle
	logic signed [acpc_pkg::CH_W-1:0] slot_map [acpc_pkg::MAP_REGS];
	logic [acpc_pkg::TICKS_W-1:0] tick_rate;

	command_t command_queue [$];
	compare_write_t due_compares [$];
	int mismatches = 0;
	int send_gap = 0;
	int hold_left = 0;
	bit rush = 1'b0;

	actuator_command_to_pwm_compare u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.slot          (slot),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_valid   (write_valid),
		.channel       (channel),
		.pulse_width   (pulse_width),
		.compare_value (compare_value)
	);

	always #5 clk = ~clk;

	// Work out the compare write that one command should cause
	function automatic compare_write_t map_command(acpc_pkg::cmd_t mode,
			logic [acpc_pkg::SLOT_W-1:0] s, logic signed [acpc_pkg::VALUE_W-1:0] v);
		compare_write_t r;
		int level;
		int width_us;
		longint ticks;
		logic signed [acpc_pkg::CH_W-1:0] phys;
		level = v;
		if (mode == acpc_pkg::CMD_RAW) begin
			if (level < -acpc_pkg::RAW_FULL)
				level = -acpc_pkg::RAW_FULL;
			if (level > acpc_pkg::RAW_FULL)
				level = acpc_pkg::RAW_FULL;
			width_us = acpc_pkg::PULSE_MID + level * acpc_pkg::PULSE_SPAN / acpc_pkg::RAW_FULL;
		end else begin
			width_us = acpc_pkg::PULSE_MID
				+ level * acpc_pkg::PULSE_SPAN / (1 << acpc_pkg::Q_FRAC);
		end
		if (width_us < acpc_pkg::PULSE_MIN)
			width_us = acpc_pkg::PULSE_MIN;
		if (width_us > acpc_pkg::PULSE_MAX)
			width_us = acpc_pkg::PULSE_MAX;
		r.write_valid = 1'b0;
		r.channel = '0;
		if (s < acpc_pkg::SLOT_COUNT && s < acpc_pkg::MAP_REGS) begin
			phys = slot_map[s[acpc_pkg::MAP_IDX_W-1:0]];
			// negative entries disable the slot
			if (!phys[acpc_pkg::CH_W-1]) begin
				r.write_valid = 1'b1;
				r.channel = phys[acpc_pkg::CHAN_W-1:0];
			end
		end
		ticks = (longint'(width_us) * longint'(tick_rate)) >>> acpc_pkg::TICKS_FRAC;
		r.pulse_width = width_us[acpc_pkg::PULSE_W-1:0];
		r.compare_value = ticks[acpc_pkg::CMP_W-1:0];
		return r;
	endfunction

	function automatic command_t random_command();
		command_t c;
		int pick;
		c.mode = acpc_pkg::cmd_t'($urandom_range(0, 1));
		// mostly mapped slots, some beyond the map
		pick = $urandom_range(0, 9);
		if (pick < 7)
			c.slot_id = acpc_pkg::SLOT_W'($urandom_range(0, acpc_pkg::MAP_REGS - 1));
		else if (pick == 7)
			c.slot_id = acpc_pkg::SLOT_W'($urandom_range(acpc_pkg::MAP_REGS,
				2 * acpc_pkg::MAP_REGS));
		else
			c.slot_id = acpc_pkg::SLOT_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			c.level = acpc_pkg::VALUE_W'($urandom);
		else if (pick < 7)
			c.level = acpc_pkg::VALUE_W'(int'($urandom_range(0, 18000)) - 9000);
		else if (pick == 7)
			c.level = acpc_pkg::VALUE_W'((1 << acpc_pkg::Q_FRAC)
				+ int'($urandom_range(0, 8)) - 4);
		else if (pick == 8)
			c.level = acpc_pkg::VALUE_W'(-(1 << acpc_pkg::Q_FRAC)
				+ int'($urandom_range(0, 8)) - 4);
		else
			c.level = acpc_pkg::VALUE_W'((($urandom_range(0, 1) != 0) ?
				acpc_pkg::RAW_FULL : -acpc_pkg::RAW_FULL) + int'($urandom_range(0, 4)) - 2);
		return c;
	endfunction

	task automatic add_command(acpc_pkg::cmd_t mode, int s, int v);
		command_t c;
		c.mode = mode;
		c.slot_id = acpc_pkg::SLOT_W'(s);
		c.level = acpc_pkg::VALUE_W'(v);
		command_queue.push_back(c);
	endtask

	task automatic write_reg(input logic [acpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [acpc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < acpc_pkg::MAP_REGS)
			slot_map[idx[acpc_pkg::MAP_IDX_W-1:0]] = data[acpc_pkg::CH_W-1:0];
		else if (idx == acpc_pkg::REG_TICKS)
			tick_rate = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_map(int m0, int m1, int m2, int m3, int ticks);
		int chans [acpc_pkg::MAP_REGS];
		chans = '{m0, m1, m2, m3};
		for (int i = 0; i < acpc_pkg::MAP_REGS; i++)
			write_reg(acpc_pkg::CFG_IDX_W'(int'(acpc_pkg::REG_MAP_SLOT0) + i),
				{13'($urandom), 3'(chans[i])});
		write_reg(acpc_pkg::REG_TICKS, acpc_pkg::CFG_DATA_W'(ticks));
	endtask

	// Hold until every queued command has gone and every write has come back
	task automatic wait_drained();
		while (command_queue.size() != 0 || in_valid || due_compares.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
		mismatches++;
	endtask

	// Present command beats, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin : drive_commands
		command_t next_cmd;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				due_compares.push_back(map_command(cmd, slot, value));
				send_gap = rush ? 0 : $urandom_range(0, 19);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (command_queue.size() > 0) begin
					next_cmd = command_queue.pop_front();
					in_valid <= 1'b1;
					cmd <= next_cmd.mode;
					slot <= next_cmd.slot_id;
					value <= next_cmd.level;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take result beats and compare them with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_writes
		compare_write_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_compares.size() == 0) begin
					report_mismatch("unexpected beat, pulse_width", int'(pulse_width), 0);
				end else begin
					want = due_compares.pop_front();
					if (write_valid !== want.write_valid)
						report_mismatch("write_valid", int'(write_valid),
							int'(want.write_valid));
					if (channel !== want.channel)
						report_mismatch("channel", int'(channel), int'(want.channel));
					if (pulse_width !== want.pulse_width)
						report_mismatch("pulse_width", int'(pulse_width),
							int'(want.pulse_width));
					if (compare_value !== want.compare_value)
						report_mismatch("compare_value", int'(compare_value),
							int'(want.compare_value));
				end
				hold_left = rush ? 0 : $urandom_range(0, 19);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : run_phases
		for (int i = 0; i < acpc_pkg::MAP_REGS; i++)
			slot_map[i] = acpc_pkg::CH_W'(i);
		tick_rate = acpc_pkg::TICKS_W'(acpc_pkg::TICKS_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset mapping: full scale, overrange, rounding toward zero, unmapped slots
		add_command(acpc_pkg::CMD_NORM, 0, 0);
		add_command(acpc_pkg::CMD_NORM, 1, 16384);
		add_command(acpc_pkg::CMD_NORM, 2, -16384);
		add_command(acpc_pkg::CMD_NORM, 3, 32767);
		add_command(acpc_pkg::CMD_NORM, 0, -32768);
		add_command(acpc_pkg::CMD_NORM, 1, -33);
		add_command(acpc_pkg::CMD_NORM, 2, 1);
		add_command(acpc_pkg::CMD_NORM, 3, -1);
		add_command(acpc_pkg::CMD_RAW, 0, 8192);
		add_command(acpc_pkg::CMD_RAW, 1, -8192);
		add_command(acpc_pkg::CMD_RAW, 2, 8193);
		add_command(acpc_pkg::CMD_RAW, 3, -8193);
		add_command(acpc_pkg::CMD_RAW, 0, 32767);
		add_command(acpc_pkg::CMD_RAW, 1, -32768);
		add_command(acpc_pkg::CMD_RAW, 2, -17);
		add_command(acpc_pkg::CMD_RAW, 3, 1);
		add_command(acpc_pkg::CMD_NORM, 4, 8192);
		add_command(acpc_pkg::CMD_RAW, 255, -4096);
		add_command(acpc_pkg::CMD_NORM, 128, 100);
		add_command(acpc_pkg::CMD_RAW, 5, 0);
		wait_drained();

		for (int phase = 1; phase <= 9; phase++) begin
			rush = (phase % 3 == 1);
			if (phase == 1) begin
				write_map(-1, 3, -4, 0, 65535);
			end else if (phase == 2) begin
				write_map(3, 2, 1, -1, 0);
				// spare indexes must leave the registers alone
				for (int k = acpc_pkg::REG_TICKS + 1; k < (1 << acpc_pkg::CFG_IDX_W); k++)
					write_reg(acpc_pkg::CFG_IDX_W'(k), acpc_pkg::CFG_DATA_W'($urandom));
			end else begin
				write_map($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7),
					($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
			end
			@(negedge clk);
			for (int n = 0; n < 67; n++)
				command_queue.push_back(random_command());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_compares.size() == 0)
			$display("actuator_command_to_pwm_compare test passed");
		else
			$display("actuator_command_to_pwm_compare test failed");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("actuator_command_to_pwm_compare test failed");
		$finish;
	end

endmodule
